// ----- rtl/rdr_pkg.sv -----
// Shared types, constants and codes of the reverb depth ramp block.
package rdr_pkg;

    localparam int DEPTH_W   = 16;
    localparam int TICKS_W   = 16;
    localparam int STEP_W    = 17;
    localparam int MAX_CORES = 2;
    localparam int MAX_CH    = 2 * MAX_CORES;
    localparam int DEF_CORES = 2;
    localparam int QDEPTH    = 2;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_KILL  = 2'd2;

    localparam logic [1:0] SEL_LEFT = 2'd1;
    localparam logic [1:0] SEL_BOTH = 2'd3;

    typedef struct packed {
        logic [1:0]                func;
        logic [1:0]                core_mask;
        logic [1:0]                channel_sel;
        logic signed [DEPTH_W-1:0] target_depth;
        logic [TICKS_W-1:0]        ramp_ticks;
    } in_item_t;

    typedef struct packed {
        logic                      core_index;
        logic signed [DEPTH_W-1:0] left_depth;
        logic signed [DEPTH_W-1:0] right_depth;
        logic                      last;
    } out_item_t;

    // Decoded command as it waits in the queue.
    typedef struct packed {
        logic [1:0]                func;
        logic [MAX_CH-1:0]         work;
        logic signed [DEPTH_W-1:0] target;
        logic [TICKS_W-1:0]        ticks;
        logic                      ticks_zero;
    } cmd_t;

    typedef struct packed {
        logic               start;
        logic [DEPTH_W-1:0] dividend;
        logic [TICKS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DEPTH_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/rdr_if.sv -----
// Valid/ready channel carrying one payload.
interface rdr_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/rdr_front.sv -----
// Front end: accepts requests, decodes them into channel work and queues them.
module rdr_front #(
    parameter int CORES = rdr_pkg::DEF_CORES
) (
    input  logic          clk,
    input  logic          rst_n,
    rdr_if.sink           cmd,
    output logic          q_valid,
    output rdr_pkg::cmd_t q_cmd,
    input  logic          q_pop
);
    import rdr_pkg::*;

    localparam int NCH   = 2 * CORES;
    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    cmd_t             mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    cmd_t             dec;
    logic             keep;
    logic             push;

    always_comb
    begin
        dec            = '0;
        dec.func       = cmd.data.func;
        dec.target     = cmd.data.target_depth;
        dec.ticks      = cmd.data.ramp_ticks;
        dec.ticks_zero = (cmd.data.ramp_ticks == '0);
        keep           = 1'b1;
        case (cmd.data.func)
            FUNC_START:
            begin
                for (int c = 0; c < CORES; c++)
                begin
                    if (cmd.data.core_mask[c])
                    begin
                        case (cmd.data.channel_sel)
                            SEL_BOTH:
                            begin
                                dec.work[2*c]   = 1'b1;
                                dec.work[2*c+1] = 1'b1;
                            end
                            SEL_LEFT: dec.work[2*c]   = 1'b1;
                            default:  dec.work[2*c+1] = 1'b1;
                        endcase
                    end
                end
            end
            FUNC_KILL:
            begin
                for (int c = 0; c < CORES; c++)
                begin
                    if (cmd.data.core_mask[c])
                    begin
                        dec.work[2*c]   = 1'b1;
                        dec.work[2*c+1] = 1'b1;
                    end
                end
            end
            FUNC_TICK:
            begin
                for (int j = 0; j < NCH; j++)
                begin
                    dec.work[j] = 1'b1;
                end
            end
            default: keep = 1'b0;
        endcase
    end

    // An unused function code is taken and dropped.
    assign cmd.ready = (cnt_reg != CNT_W'(QDEPTH));
    assign push      = cmd.valid && cmd.ready && keep;
    assign q_valid   = (cnt_reg != '0);
    assign q_cmd     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (q_pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ----- rtl/rdr_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
module rdr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rdr_pkg::div_req_t req,
    output rdr_pkg::div_rsp_t rsp
);
    import rdr_pkg::*;

    localparam int DIV_W = DEPTH_W;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] diff;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= TICKS_W'(req.divisor);
                cnt_reg  <= CNT_W'(DIV_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!diff[DIV_W+1])
                begin
                    rem_reg <= diff[DIV_W-1:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[DIV_W-1:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/rdr_back.sv -----
// Back end: walks the channels of a queued command, updates ramp state and emits depth pairs.
module rdr_back #(
    parameter int CORES = rdr_pkg::DEF_CORES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  rdr_pkg::cmd_t     q_cmd,
    output logic              q_pop,
    output rdr_pkg::div_req_t div_req,
    input  rdr_pkg::div_rsp_t div_rsp,
    rdr_if.source             result
);
    import rdr_pkg::*;

    localparam int NCH    = 2 * CORES;
    localparam int CH_W   = $clog2(NCH);
    localparam int CORE_W = (CORES > 1) ? $clog2(CORES) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_EMIT} state_t;

    state_t                          state_reg, state_next;
    cmd_t                            cmd_reg, cmd_next;
    logic [CH_W-1:0]                 ch_reg, ch_next;
    logic [NCH-1:0]                  emask_reg, emask_next;
    logic                            neg_reg, neg_next;
    logic [1:0][DEPTH_W-1:0]         cur_reg [CORES];
    logic [1:0][DEPTH_W-1:0]         cur_next [CORES];
    logic signed [DEPTH_W-1:0]       tgt_reg [NCH];
    logic signed [DEPTH_W-1:0]       tgt_next [NCH];
    logic signed [STEP_W-1:0]        step_reg [NCH];
    logic signed [STEP_W-1:0]        step_next [NCH];
    logic                            out_valid_reg, out_valid_next;
    out_item_t                       out_data_reg, out_data_next;

    logic [CH_W-1:0]                 core_bits;
    logic [CORE_W-1:0]               core_sel;
    logic                            side;
    logic signed [DEPTH_W-1:0]       cur_d;
    logic signed [DEPTH_W-1:0]       tgt_d;
    logic signed [STEP_W-1:0]        step_d;
    logic signed [DEPTH_W+1:0]       sum;
    logic                            clamp;
    logic signed [DEPTH_W-1:0]       nd;
    logic signed [STEP_W-1:0]        change;
    logic [STEP_W-1:0]               mag;
    logic [STEP_W-1:0]               q_ext;
    logic signed [STEP_W-1:0]        step_new;
    logic [NCH-1:0]                  pop_mask;
    logic                            is_last;
    logic                            advance;

    assign core_bits = ch_reg >> 1;
    assign core_sel  = CORE_W'(core_bits);
    assign side      = ch_reg[0];
    assign cur_d     = cur_reg[core_sel][side];
    assign tgt_d     = tgt_reg[ch_reg];
    assign step_d    = step_reg[ch_reg];

    // Tick arithmetic: add the step and clamp at the target on the far side.
    assign sum   = {{2{cur_d[DEPTH_W-1]}}, cur_d} + {step_d[STEP_W-1], step_d};
    assign clamp = step_d[STEP_W-1] ? (sum < $signed({{2{tgt_d[DEPTH_W-1]}}, tgt_d}))
                                    : (sum > $signed({{2{tgt_d[DEPTH_W-1]}}, tgt_d}));
    assign nd    = clamp ? tgt_d : sum[DEPTH_W-1:0];

    // Start arithmetic: signed change and its magnitude for the divider.
    assign change = {cmd_reg.target[DEPTH_W-1], cmd_reg.target} - {cur_d[DEPTH_W-1], cur_d};
    assign mag    = change[STEP_W-1] ? -change : change;

    // A zero quotient means the change is smaller than the ramp time.
    assign q_ext    = {1'b0, div_rsp.quotient};
    assign step_new = (div_rsp.quotient == '0) ? (neg_reg ? -STEP_W'(1) : STEP_W'(1))
                                               : (neg_reg ? -q_ext : q_ext);

    // Channels that will emit are known when the command is taken.
    always_comb
    begin
        for (int j = 0; j < NCH; j++)
        begin
            case (q_cmd.func)
                FUNC_TICK:  pop_mask[j] = (step_reg[j] != '0);
                FUNC_START: pop_mask[j] = q_cmd.work[j] && q_cmd.ticks_zero;
                default:    pop_mask[j] = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        is_last = 1'b1;
        for (int j = 0; j < NCH; j++)
        begin
            if ((CH_W'(j) > ch_reg) && emask_reg[j])
            begin
                is_last = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        ch_next          = ch_reg;
        emask_next       = emask_reg;
        neg_next         = neg_reg;
        cur_next         = cur_reg;
        tgt_next         = tgt_reg;
        step_next        = step_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_data_next    = out_data_reg;
        q_pop            = 1'b0;
        advance          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = mag[DEPTH_W-1:0];
        div_req.divisor  = cmd_reg.ticks;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    ch_next    = '0;
                    emask_next = pop_mask;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!cmd_reg.work[ch_reg])
                begin
                    advance = 1'b1;
                end
                else
                begin
                    case (cmd_reg.func)
                        FUNC_TICK:
                        begin
                            if (step_d != '0)
                            begin
                                cur_next[core_sel][side] = nd;
                                if (nd == tgt_d)
                                begin
                                    step_next[ch_reg] = '0;
                                end
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                advance = 1'b1;
                            end
                        end
                        FUNC_START:
                        begin
                            step_next[ch_reg] = '0;
                            if (cmd_reg.ticks_zero)
                            begin
                                cur_next[core_sel][side] = cmd_reg.target;
                                state_next = ST_EMIT;
                            end
                            else if (cmd_reg.target == cur_d)
                            begin
                                advance = 1'b1;
                            end
                            else
                            begin
                                tgt_next[ch_reg] = cmd_reg.target;
                                neg_next         = change[STEP_W-1];
                                div_req.start    = 1'b1;
                                state_next       = ST_DIV;
                            end
                        end
                        FUNC_KILL:
                        begin
                            step_next[ch_reg] = '0;
                            advance           = 1'b1;
                        end
                        default: advance = 1'b1;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    step_next[ch_reg] = step_new;
                    advance           = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.core_index  = core_bits[0];
                    out_data_next.left_depth  = cur_reg[core_sel][0];
                    out_data_next.right_depth = cur_reg[core_sel][1];
                    out_data_next.last        = is_last;
                    advance                   = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (advance)
        begin
            if (ch_reg == CH_W'(NCH - 1))
            begin
                state_next = ST_IDLE;
            end
            else
            begin
                ch_next    = ch_reg + 1'b1;
                state_next = ST_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            ch_reg        <= '0;
            emask_reg     <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int c = 0; c < CORES; c++)
            begin
                cur_reg[c] <= '0;
            end
            for (int j = 0; j < NCH; j++)
            begin
                tgt_reg[j]  <= '0;
                step_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            ch_reg        <= ch_next;
            emask_reg     <= emask_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            cur_reg       <= cur_next;
            tgt_reg       <= tgt_next;
            step_reg      <= step_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // A depth pair goes out only for a channel planned to emit when the command was taken.
    a_emit_planned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> emask_reg[ch_reg])
        else $error("emission on a channel outside the planned set");

    // The divider finishes only while the sequencer waits on it.
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider result with no waiting start");

    // Division is used only for a timed start.
    a_div_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ((cmd_reg.func == FUNC_START) && !cmd_reg.ticks_zero))
        else $error("divider wait outside a timed start");

endmodule

// ----- rtl/reverb_depth_ramp_core.sv -----
// Top level of the reverb depth ramp: front decoder, command queue, sequencer and divider.
// A request accepted into the queue is taken by the sequencer in the cycle after when
// it is idle, otherwise after the command ahead of it finishes.
// Each command then scans every channel, with one emit step per emitted result (held under
// output backpressure) and a divider wait per channel whose timed start needs the serial divider.
// The queue takes new requests, while it has room, as the sequencer works on an earlier command.
// Reset (rst_n low, asynchronous): all depths, targets and steps clear, no ramp active.
module reverb_depth_ramp_core #(
    parameter int CORES = rdr_pkg::DEF_CORES
) (
    input logic   clk,
    input logic   rst_n,
    rdr_if.sink   cmd,
    rdr_if.source result
);
    import rdr_pkg::*;

    // Queue between the front decoder and the back sequencer. The front keeps taking
    // requests, up to QDEPTH queued, while the back is busy dividing or waits on a stalled result.
    logic     q_valid;
    cmd_t     q_cmd;
    logic     q_pop;

    // Divider control and response between the sequencer and the divider.
    div_req_t div_req;
    div_rsp_t div_rsp;

    // The front turns each request into a per-channel work mask; an unused
    // function code is accepted and dropped there.
    rdr_front #(
        .CORES (CORES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // The divider works out change / ramp time for a timed start.
    rdr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // The back visits core 0 left, core 0 right, core 1 left and so on, holds all
    // ramp state and drives the result register.
    rdr_back #(
        .CORES (CORES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .result  (result)
    );

endmodule

// ----- tb/reverb_depth_ramp_checker.sv -----
// Checker for the reverb depth ramp: watches both channels, predicts depth writes and compares them.
module reverb_depth_ramp_checker
    import rdr_pkg::*;
#(
    parameter int CORES = DEF_CORES
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_ready,
    input  in_item_t  cmd_data,
    input  logic      result_valid,
    input  logic      result_ready,
    input  out_item_t result_data,
    output int        mismatches,
    output int        writes_due
);

    // Channel index is core*2 + channel, with channel 0 the left one.
    logic signed [DEPTH_W-1:0] depth_now  [MAX_CH];
    logic signed [DEPTH_W-1:0] depth_goal [MAX_CH];
    logic signed [STEP_W-1:0]  depth_step [MAX_CH];

    out_item_t depth_writes_q[$];
    int        fail_tally = 0;
    int        due_now = 0;

    assign mismatches = fail_tally;
    assign writes_due = due_now;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        fail_tally++;
    endtask

    function automatic void queue_pair(input int core);
        out_item_t w;
        w.core_index  = core[0];
        w.left_depth  = depth_now[2*core];
        w.right_depth = depth_now[2*core + 1];
        w.last        = 1'b0;
        depth_writes_q.push_back(w);
    endfunction

    function automatic void start_ramp(input int ch, input logic signed [DEPTH_W-1:0] goal,
                                       input logic [TICKS_W-1:0] ticks);
        int change;
        int mag;
        depth_step[ch] = '0;
        if (ticks == '0)
        begin
            depth_now[ch] = goal;
            queue_pair(ch / 2);
        end
        else if (goal != depth_now[ch])
        begin
            change = int'(goal) - int'(depth_now[ch]);
            mag = (change < 0) ? -change : change;
            depth_goal[ch] = goal;
            if (mag >= int'(ticks))
                depth_step[ch] = STEP_W'(change / int'(ticks));
            else
                depth_step[ch] = (change > 0) ? 17'sd1 : -17'sd1;
        end
    endfunction

    function automatic void advance_ramp(input int ch);
        int next_depth;
        if (depth_step[ch] != '0)
        begin
            next_depth = int'(depth_now[ch]) + int'(depth_step[ch]);
            if (depth_step[ch] > 0 && next_depth > int'(depth_goal[ch]))
                next_depth = int'(depth_goal[ch]);
            if (depth_step[ch] < 0 && next_depth < int'(depth_goal[ch]))
                next_depth = int'(depth_goal[ch]);
            depth_now[ch] = DEPTH_W'(next_depth);
            queue_pair(ch / 2);
            if (next_depth == int'(depth_goal[ch]))
                depth_step[ch] = '0;
        end
    endfunction

    function automatic void predict_depth_writes(input in_item_t req);
        int queued_before;
        queued_before = depth_writes_q.size();
        for (int core = 0; core < CORES; core++)
        begin
            if (req.func == FUNC_TICK)
            begin
                advance_ramp(2*core);
                advance_ramp(2*core + 1);
            end
            else if (req.core_mask[core])
            begin
                if (req.func == FUNC_START)
                begin
                    if (req.channel_sel == SEL_BOTH)
                    begin
                        start_ramp(2*core, req.target_depth, req.ramp_ticks);
                        start_ramp(2*core + 1, req.target_depth, req.ramp_ticks);
                    end
                    else
                    begin
                        start_ramp(2*core + ((req.channel_sel == SEL_LEFT) ? 0 : 1),
                                   req.target_depth, req.ramp_ticks);
                    end
                end
                else if (req.func == FUNC_KILL)
                begin
                    depth_step[2*core]     = '0;
                    depth_step[2*core + 1] = '0;
                end
            end
        end
        if (depth_writes_q.size() > queued_before)
            depth_writes_q[depth_writes_q.size() - 1].last = 1'b1;
    endfunction

    task automatic compare_write(input out_item_t got);
        out_item_t want;
        if (depth_writes_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected write core %0d L %0d R %0d last %0b",
                                      got.core_index, got.left_depth, got.right_depth,
                                      got.last));
        end
        else
        begin
            want = depth_writes_q.pop_front();
            if (got.core_index !== want.core_index)
                report_mismatch($sformatf("core_index got %0d want %0d",
                                          got.core_index, want.core_index));
            if (got.left_depth !== want.left_depth)
                report_mismatch($sformatf("left_depth got %0d want %0d",
                                          got.left_depth, want.left_depth));
            if (got.right_depth !== want.right_depth)
                report_mismatch($sformatf("right_depth got %0d want %0d",
                                          got.right_depth, want.right_depth));
            if (got.last !== want.last)
                report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
        end
    endtask

    // The model state is updated in place by the prediction functions, so reset
    // clears it the same way.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CH; i++)
            begin
                depth_now[i]  = '0;
                depth_goal[i] = '0;
                depth_step[i] = '0;
            end
            depth_writes_q.delete();
            due_now <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
                compare_write(result_data);
            if (cmd_valid && cmd_ready)
                predict_depth_writes(cmd_data);
            due_now <= depth_writes_q.size();
        end
    end

endmodule

// ----- tb/reverb_depth_ramp_core_test.sv -----
// Top of the reverb depth ramp test: clock, reset, request stimulus, result backpressure and verdict.
module reverb_depth_ramp_core_test;
    import rdr_pkg::*;

    // The run is bounded well above the slowest legal run: about 280 requests, each of
    // which may need a timed start through the divider plus four results under a stalling receiver.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 230;
    localparam int DRAIN_CYCLES = 200;

    // Channel select codes that the package leaves unnamed; both of them pick the right channel.
    localparam logic [1:0] SEL_RIGHT     = 2'd2;
    localparam logic [1:0] SEL_RIGHT_ALT = 2'd0;
    // The one function code that the block ignores.
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic steady = 1'b0;
    logic cmd_took = 1'b0;
    int   cycle_count = 0;
    int   mismatches;
    int   writes_due;

    rdr_if #(.payload_t(in_item_t))  cmd_ch ();
    rdr_if #(.payload_t(out_item_t)) result_ch ();

    reverb_depth_ramp_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (result_ch)
    );

    reverb_depth_ramp_checker ramp_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_ch.valid),
        .cmd_ready    (cmd_ch.ready),
        .cmd_data     (cmd_ch.data),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .result_data  (result_ch.data),
        .mismatches   (mismatches),
        .writes_due   (writes_due)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Every input starts at a known value.
    initial
    begin
        cmd_ch.valid    = 1'b0;
        cmd_ch.data     = '0;
        result_ch.ready = 1'b0;
    end

    // The handshake is captured at the rising edge, so the stimulus, which runs on the
    // falling edge, sees whether the request it held was taken without racing the block.
    always @(posedge clk)
    begin
        cmd_took <= cmd_ch.valid && cmd_ch.ready;
    end

    // The receiver stalls about one cycle in three, except inside the steady stretch.
    always @(negedge clk)
    begin
        result_ch.ready <= steady || ($urandom_range(99) >= 33);
    end

    // A stuck block or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d writes outstanding", cycle_count, writes_due);
            $display("** reverb_depth_ramp_core: FAILED **");
            $finish;
        end
    end

    function automatic in_item_t pack_request(input logic [1:0] func, input logic [1:0] mask,
                                              input logic [1:0] sel,
                                              input logic signed [DEPTH_W-1:0] target,
                                              input logic [TICKS_W-1:0] ticks);
        in_item_t req;
        req.func         = func;
        req.core_mask    = mask;
        req.channel_sel  = sel;
        req.target_depth = target;
        req.ramp_ticks   = ticks;
        return req;
    endfunction

    // Holds one request until the block takes it. The random gap is decided up front so
    // that valid gets one assignment per falling edge and never drops between back-to-back
    // requests.
    task automatic send_request(input in_item_t req);
        int gap;
        gap = 0;
        if (!steady)
        begin
            while ($urandom_range(99) < 33)
                gap++;
        end
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= req;
        @(negedge clk);
        while (!cmd_took)
            @(negedge clk);
    endtask

    task automatic send_tick();
        send_request(pack_request(FUNC_TICK, 2'($urandom), 2'($urandom), 16'($urandom),
                                  16'($urandom)));
    endtask

    // Random traffic mixes ticks with ramps that mostly finish within a few ticks, kills,
    // full-range durations that crawl by one, and requests that the block ignores.
    initial
    begin
        int counted;
        int roll;
        int pick;
        logic [1:0] func;
        logic [1:0] mask;
        logic signed [DEPTH_W-1:0] target;
        logic signed [DEPTH_W-1:0] last_target;
        logic [TICKS_W-1:0] ticks;

        last_target = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: immediate writes at both extremes, the largest possible upward step,
        // a full-range downward ramp, a slow ramp, a cancel by an equal target, a kill, a start
        // with no core selected, the unused function code and the full-scale duration.
        send_request(pack_request(FUNC_START, 2'b11, SEL_BOTH, 16'sh7FFF, 16'd0));
        send_request(pack_request(FUNC_START, 2'b01, SEL_LEFT, -16'sh8000, 16'd0));
        send_request(pack_request(FUNC_START, 2'b01, SEL_LEFT, 16'sh7FFF, 16'd1));
        send_tick();
        send_request(pack_request(FUNC_START, 2'b10, SEL_RIGHT, -16'sh8000, 16'd3));
        repeat (4) send_tick();
        send_request(pack_request(FUNC_START, 2'b10, SEL_RIGHT_ALT, 16'sd100, 16'hFFFF));
        send_tick();
        send_request(pack_request(FUNC_START, 2'b10, SEL_RIGHT_ALT, -16'sd32767, 16'd5));
        send_tick();
        send_request(pack_request(FUNC_START, 2'b01, SEL_BOTH, -16'sd5, 16'd7));
        send_tick();
        send_request(pack_request(FUNC_KILL, 2'b01, SEL_BOTH, 16'sd0, 16'd0));
        send_tick();
        send_request(pack_request(FUNC_START, 2'b00, SEL_BOTH, 16'sd1, 16'd0));
        send_request(pack_request(FUNC_UNUSED, 2'b11, SEL_BOTH, -16'sd1, 16'hFFFF));
        send_request(pack_request(FUNC_START, 2'b11, SEL_BOTH, -16'sh8000, 16'hFFFF));
        send_tick();
        send_tick();
        send_request(pack_request(FUNC_KILL, 2'b11, SEL_BOTH, 16'sd0, 16'd0));
        send_tick();
        send_request(pack_request(FUNC_START, 2'b11, SEL_BOTH, 16'sd0, 16'd0));

        // Random part. Requests that the block ignores do not advance the count.
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            steady <= (counted >= 100 && counted < 160);
            roll = $urandom_range(99);
            mask = 2'($urandom);
            if (roll < 45)
            begin
                send_tick();
                counted++;
            end
            else if (roll < 82)
            begin
                if ($urandom_range(4) == 0)
                    target = last_target;
                else
                    target = 16'($urandom);
                pick = $urandom_range(9);
                if (pick == 0)
                    ticks = '0;
                else if (pick == 1)
                    ticks = 16'($urandom);
                else
                    ticks = 16'($urandom_range(8, 1));
                if (mask == 2'b00)
                    mask = 2'($urandom_range(3, 1));
                send_request(pack_request(FUNC_START, mask, 2'($urandom), target, ticks));
                last_target = target;
                counted++;
            end
            else if (roll < 92)
            begin
                send_request(pack_request(FUNC_KILL, mask, 2'($urandom), 16'($urandom),
                                          16'($urandom)));
                if (mask != 2'b00)
                    counted++;
            end
            else
            begin
                // Noise: the unused code, or a start that selects no core.
                func = ($urandom_range(1) == 0) ? FUNC_UNUSED : FUNC_START;
                send_request(pack_request(func, (func == FUNC_START) ? 2'b00 : mask,
                                          2'($urandom), 16'($urandom), 16'($urandom)));
            end
        end
        steady <= 1'b0;
        cmd_ch.valid <= 1'b0;

        // Wait for every predicted write, then give the block time to show anything extra.
        while (writes_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("** reverb_depth_ramp_core: PASSED **");
        else
            $display("** reverb_depth_ramp_core: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rdr_pkg.sv
rtl/rdr_if.sv
rtl/rdr_front.sv
rtl/rdr_div.sv
rtl/rdr_back.sv
rtl/reverb_depth_ramp_core.sv
tb/reverb_depth_ramp_checker.sv
tb/reverb_depth_ramp_core_test.sv
